@@ design/token_budget_threshold_monitor_core_defines.svh @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUDGET_THRESHOLD_MONITOR_CORE_DEFINES_SVH
`define TOKEN_BUDGET_THRESHOLD_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TBTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TBTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tbtm_pkg.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: package
// Widths, codes, shared types and decode helpers.
// ----------------------------------------------------------------------------
package tbtm_pkg;

    localparam int COUNT_WIDTH = 40;
    localparam int AMOUNT_W    = 24;
    localparam int LIMIT_W     = 32;
    localparam int TOTAL_W     = 41;
    localparam int PCT_W       = 7;
    localparam int AXIS_W      = 2;
    localparam int N_AXES      = 3;
    localparam int N_PCT       = 3;
    localparam int N_MARKS     = N_AXES * N_PCT;
    localparam int MARK_IDX_W  = $clog2(N_MARKS);
    localparam int PROD_W      = LIMIT_W + PCT_W;
    localparam int CMP_W       = COUNT_WIDTH + 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_INPUT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd1;
    localparam logic [1:0] REG_TOTAL_LIMIT  = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_INPUT  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_OUTPUT = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_TOTAL  = 2'd2;

    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;
    localparam logic [PCT_W-1:0] PCT_HIGH = 7'd80;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;

    localparam logic [PCT_W-1:0] PCT_TABLE [N_PCT] = '{PCT_HALF, PCT_HIGH, PCT_FULL};

    typedef struct packed {
        logic [N_AXES-1:0]                          en;
        logic [N_AXES-1:0][N_PCT-1:0][PROD_W-1:0]   prod;
    } tbtm_limits_t;

    typedef struct packed {
        logic [N_MARKS-1:0] marks;
        logic [TOTAL_W-1:0] total;
    } tbtm_entry_t;

    function automatic logic [CMP_W-1:0] tbtm_times100(input logic [CMP_W-1:0] v);
        return (v << 6) + (v << 5) + (v << 2);
    endfunction

    function automatic logic [PROD_W-1:0] tbtm_scale(input logic [LIMIT_W-1:0] lim,
                                                     input logic [PCT_W-1:0] pct);
        return PROD_W'(lim) * PROD_W'(pct);
    endfunction

    function automatic logic [AXIS_W-1:0] tbtm_mark_axis(input logic [MARK_IDX_W-1:0] idx);
        logic [AXIS_W-1:0] axis;
        unique case (idx) inside
            4'd0, 4'd1, 4'd2: axis = AXIS_INPUT;
            4'd3, 4'd4, 4'd5: axis = AXIS_OUTPUT;
            default:          axis = AXIS_TOTAL;
        endcase
        return axis;
    endfunction

    function automatic logic [PCT_W-1:0] tbtm_mark_pct(input logic [MARK_IDX_W-1:0] idx);
        logic [PCT_W-1:0] pct;
        unique case (idx) inside
            4'd0, 4'd3, 4'd6: pct = PCT_HALF;
            4'd1, 4'd4, 4'd7: pct = PCT_HIGH;
            default:          pct = PCT_FULL;
        endcase
        return pct;
    endfunction

endpackage

@@ design/tbtm_regs.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: limit registers
// APB register file for the three limits with pre-scaled threshold products.
// ----------------------------------------------------------------------------
module tbtm_regs
    import tbtm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output tbtm_limits_t        limits
);

    logic [N_AXES-1:0][LIMIT_W-1:0]               lim_reg;
    logic [N_AXES-1:0][N_PCT-1:0][PROD_W-1:0]     prod_reg;
    logic [1:0]                                   idx;
    logic                                         wr_en;

    assign idx   = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg  <= '0;
            prod_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx) inside
                REG_INPUT_LIMIT, REG_OUTPUT_LIMIT, REG_TOTAL_LIMIT:
                begin
                    lim_reg[idx] <= pwdata[LIMIT_W-1:0];
                    for (int k = 0; k < N_PCT; k++)
                    begin
                        prod_reg[idx][k] <= tbtm_scale(pwdata[LIMIT_W-1:0], PCT_TABLE[k]);
                    end
                end
                default:
                begin
                    // drop writes outside the map
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx) inside
            REG_INPUT_LIMIT, REG_OUTPUT_LIMIT, REG_TOTAL_LIMIT:
                prdata = DATA_W'(lim_reg[idx]);
            default:
                prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int a = 0; a < N_AXES; a++)
        begin
            limits.en[a] = |lim_reg[a];
        end
        limits.prod = prod_reg;
    end

endmodule

@@ design/tbtm_front.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: front end
// Accepts requests, updates the saturating counters and classifies crossings.
// ----------------------------------------------------------------------------
module tbtm_front
    import tbtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [AMOUNT_W-1:0]   input_amount,
    input  logic [AMOUNT_W-1:0]   output_amount,
    input  tbtm_limits_t          limits,
    input  logic                  queue_full,
    output logic                  push,
    output tbtm_entry_t           entry
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [COUNT_WIDTH-1:0]     input_used_reg;
    logic [COUNT_WIDTH-1:0]     input_used_next;
    logic [COUNT_WIDTH-1:0]     output_used_reg;
    logic [COUNT_WIDTH-1:0]     output_used_next;
    logic [N_MARKS-1:0]         fired_reg;
    logic [N_MARKS-1:0]         fired_next;
    logic [COUNT_WIDTH:0]       in_sum;
    logic [COUNT_WIDTH:0]       out_sum;
    logic [COUNT_WIDTH:0]       total_sum;
    logic [N_AXES-1:0][CMP_W-1:0] used100;
    logic [N_MARKS-1:0]         crossed;
    logic [N_MARKS-1:0]         new_marks;
    logic                       accept;

    assign push      = s1_valid_reg && !queue_full;
    assign req_ready = !s1_valid_reg || !queue_full;
    assign accept    = req_valid && req_ready;

    assign in_sum  = {1'b0, input_used_reg} + (COUNT_WIDTH + 1)'(input_amount);
    assign out_sum = {1'b0, output_used_reg} + (COUNT_WIDTH + 1)'(output_amount);

    // saturate at full counter width
    assign input_used_next  = in_sum[COUNT_WIDTH]  ? '1 : in_sum[COUNT_WIDTH-1:0];
    assign output_used_next = out_sum[COUNT_WIDTH] ? '1 : out_sum[COUNT_WIDTH-1:0];

    assign total_sum = {1'b0, input_used_reg} + {1'b0, output_used_reg};

    always_comb
    begin
        used100[AXIS_INPUT]  = tbtm_times100(CMP_W'(input_used_reg));
        used100[AXIS_OUTPUT] = tbtm_times100(CMP_W'(output_used_reg));
        used100[AXIS_TOTAL]  = tbtm_times100(CMP_W'(total_sum));
        for (int a = 0; a < N_AXES; a++)
        begin
            for (int k = 0; k < N_PCT; k++)
            begin
                crossed[a * N_PCT + k] = limits.en[a]
                                         && (used100[a] >= CMP_W'(limits.prod[a][k]));
            end
        end
    end

    assign new_marks   = crossed & ~fired_reg;
    assign entry.marks = new_marks;
    assign entry.total = TOTAL_W'(total_sum);

    assign fired_next    = push ? (fired_reg | new_marks) : fired_reg;
    assign s1_valid_next = accept || (s1_valid_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            input_used_reg  <= '0;
            output_used_reg <= '0;
            fired_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fired_reg    <= fired_next;
            if (accept)
            begin
                input_used_reg  <= input_used_next;
                output_used_reg <= output_used_next;
            end
        end
    end

endmodule

@@ design/tbtm_queue.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: work queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
module tbtm_queue
    import tbtm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tbtm_entry_t   push_entry,
    output logic          full,
    input  logic          pop,
    output tbtm_entry_t   head,
    output logic          empty
);

    tbtm_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wptr_reg;
    logic [QPTR_W-1:0]    rptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/tbtm_back.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: back end
// Serializes crossing events and the final total into the output register.
// ----------------------------------------------------------------------------
module tbtm_back
    import tbtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbtm_entry_t           head,
    input  logic                  queue_empty,
    output logic                  pop,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output logic                  event_kind,
    output logic [AXIS_W-1:0]     axis_code,
    output logic [PCT_W-1:0]      percent,
    output logic [TOTAL_W-1:0]    total_used,
    output logic                  last
);

    logic                      cur_valid_reg;
    logic [N_MARKS-1:0]        cur_marks_reg;
    logic [N_MARKS-1:0]        cur_marks_next;
    logic [TOTAL_W-1:0]        cur_total_reg;
    logic                      evt_valid_reg;
    logic                      kind_reg;
    logic [AXIS_W-1:0]         axis_reg;
    logic [PCT_W-1:0]          pct_reg;
    logic [TOTAL_W-1:0]        total_reg;
    logic                      last_reg;
    logic [MARK_IDX_W-1:0]     sel;
    logic                      has_evt;
    logic                      emit;
    logic                      emit_final;

    // lowest pending mark first
    always_comb
    begin
        sel = '0;
        for (int i = N_MARKS - 1; i >= 0; i--)
        begin
            if (cur_marks_reg[i])
            begin
                sel = MARK_IDX_W'(i);
            end
        end
    end

    assign has_evt    = |cur_marks_reg;
    assign emit       = cur_valid_reg && (!evt_valid_reg || evt_ready);
    assign emit_final = emit && !has_evt;
    assign pop        = !queue_empty && (!cur_valid_reg || emit_final);

    always_comb
    begin
        cur_marks_next = cur_marks_reg;
        if (pop)
        begin
            cur_marks_next = head.marks;
        end
        else if (emit && has_evt)
        begin
            cur_marks_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (emit_final)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_marks_reg <= cur_marks_next;
        if (pop)
        begin
            cur_total_reg <= head.total;
        end
        if (emit)
        begin
            total_reg <= cur_total_reg;
            if (has_evt)
            begin
                kind_reg <= KIND_EVENT;
                axis_reg <= tbtm_mark_axis(sel);
                pct_reg  <= tbtm_mark_pct(sel);
                last_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= KIND_FINAL;
                axis_reg <= AXIS_INPUT;
                pct_reg  <= PCT_NONE;
                last_reg <= 1'b1;
            end
        end
    end

    assign evt_valid  = evt_valid_reg;
    assign event_kind = kind_reg;
    assign axis_code  = axis_reg;
    assign percent    = pct_reg;
    assign total_used = total_reg;
    assign last       = last_reg;

endmodule

@@ design/token_budget_threshold_monitor_core.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: top level
// Usage counters with per-axis 50/80/100 percent threshold events.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready, input_amount, output_amount): each
// request adds both amounts to two saturating counters. Result channel
// (evt_valid/evt_ready): per request, one event for each axis/percent pair
// crossed for the first time (input, output, total; 50, 80, 100), then a
// final result with last set carrying the running total.
// Limits are set over the APB port at 0x0, 0x4 and 0x8; zero disables.
// A taken request is held in the front stage, then the queue, then the back
// end's current-request register, before its first result leaves the output
// register. Throughput: one result per cycle from the back end while evt_ready
// is high, and requests with no events flow one per cycle.
// The front end keeps taking requests while results are stalled until the
// two-entry queue and the front stage fill; then req_ready drops.
// Reset clears counters, fired marks, limits and all valid state.
// ----------------------------------------------------------------------------
module token_budget_threshold_monitor_core
    import tbtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [AMOUNT_W-1:0]   input_amount,
    input  logic [AMOUNT_W-1:0]   output_amount,
    output logic                  evt_valid,
    input  logic                  evt_ready,
    output logic                  event_kind,
    output logic [AXIS_W-1:0]     axis_code,
    output logic [PCT_W-1:0]      percent,
    output logic [TOTAL_W-1:0]    total_used,
    output logic                  last
);

    tbtm_limits_t   limits;
    tbtm_entry_t    push_entry;
    tbtm_entry_t    head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    assign pready = 1'b1;

    tbtm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .limits  (limits)
    );

    tbtm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .input_amount  (input_amount),
        .output_amount (output_amount),
        .limits        (limits),
        .queue_full    (queue_full),
        .push          (push),
        .entry         (push_entry)
    );

    tbtm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .empty      (queue_empty)
    );

    tbtm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .evt_valid   (evt_valid),
        .evt_ready   (evt_ready),
        .event_kind  (event_kind),
        .axis_code   (axis_code),
        .percent     (percent),
        .total_used  (total_used),
        .last        (last)
    );

endmodule

@@ design/tbtm_checker.sv @@
// ----------------------------------------------------------------------------
// Token budget threshold monitor: port checker
// Result-channel properties observed at the top-level ports.
// ----------------------------------------------------------------------------
`include "token_budget_threshold_monitor_core_defines.svh"

module tbtm_checker
    import tbtm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  evt_valid,
    input  logic                  evt_ready,
    input  logic                  event_kind,
    input  logic [AXIS_W-1:0]     axis_code,
    input  logic [PCT_W-1:0]      percent,
    input  logic [TOTAL_W-1:0]    total_used,
    input  logic                  last
);

    logic                                 stall;
    logic                                 evt_take;
    logic                                 is_event;
    logic                                 is_final;
    logic                                 event_ok;
    logic                                 final_ok;
    logic                                 rise_check;
    logic                                 total_ok;
    logic                                 take_seen_reg;
    logic [TOTAL_W-1:0]                   total_seen_reg;
    logic [1+AXIS_W+PCT_W+TOTAL_W:0]      res_bits;

    assign stall      = evt_valid && !evt_ready;
    assign evt_take   = evt_valid && evt_ready;
    assign is_event   = evt_valid && (event_kind == KIND_EVENT);
    assign is_final   = evt_valid && (event_kind == KIND_FINAL);
    assign event_ok   = !last
                        && ((axis_code == AXIS_INPUT) || (axis_code == AXIS_OUTPUT)
                            || (axis_code == AXIS_TOTAL))
                        && ((percent == PCT_HALF) || (percent == PCT_HIGH)
                            || (percent == PCT_FULL));
    assign final_ok   = last && (axis_code == AXIS_INPUT) && (percent == PCT_NONE);
    assign rise_check = evt_take && take_seen_reg;
    assign total_ok   = (total_used >= total_seen_reg);
    assign res_bits   = {event_kind, axis_code, percent, total_used, last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_seen_reg <= 1'b0;
        end
        else if (evt_take)
        begin
            take_seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            total_seen_reg <= total_used;
        end
    end

    `TBTM_ASSERT_NEXT(a_hold, stall, evt_valid && $stable(res_bits), "result changed in stall")
    `TBTM_ASSERT_NOW(a_event_fields, is_event, event_ok, "bad threshold event fields")
    `TBTM_ASSERT_NOW(a_final_fields, is_final, final_ok, "bad final result fields")
    `TBTM_ASSERT_NOW(a_total_rise, rise_check, total_ok, "running total decreased")

endmodule

bind token_budget_threshold_monitor_core tbtm_checker u_tbtm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt_valid  (evt_valid),
    .evt_ready  (evt_ready),
    .event_kind (event_kind),
    .axis_code  (axis_code),
    .percent    (percent),
    .total_used (total_used),
    .last       (last)
);
